// ===== rtl/record_filter_substring_match_top_macros.svh =====
// Assertion macros shared by the record filter checkers.
`ifndef RECORD_FILTER_SUBSTRING_MATCH_TOP_MACROS_SVH
`define RECORD_FILTER_SUBSTRING_MATCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfsm_pkg.sv =====
// Shared types, widths and helpers of the record filter.
package rfsm_pkg;

  localparam int unsigned QueryMaxDefault = 16;
  localparam int unsigned QueryChars      = 16;
  localparam int unsigned QueryLenW       = 5;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned CategoryW       = 4;
  localparam int unsigned CategoryN       = 16;
  localparam int unsigned DateW           = 32;
  localparam int unsigned TagW            = 16;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned EnableW         = 3;

  // bit positions in test_enables
  localparam int unsigned EnCategory = 0;
  localparam int unsigned EnDate     = 1;
  localparam int unsigned EnTag      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQueryFirst   = 3'd0,
    CfgQueryLast    = 3'd1,
    CfgQueryLength  = 3'd2,
    CfgCategoryMask = 3'd3,
    CfgRangeStart   = 3'd4,
    CfgRangeEnd     = 3'd5,
    CfgTagMask      = 3'd6,
    CfgTestEnables  = 3'd7
  } cfg_idx_e;

  // ASCII A-Z to lower case, everything else unchanged
  function automatic logic [ByteW-1:0] fold_char(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

endpackage

// ===== rtl/record_filter_substring_match_top.sv =====
// Record filter: case-insensitive substring search plus category, date and tag tests.
//
// Each request carries at most one text byte of a record; the request flagged
// record_end yields one verdict (accepted, text_found). One request is taken
// every clock cycle unless a record end waits in the input register for a
// stalled output. A verdict passes the input register, then a single compare
// stage into the result register. The compare stage folds the new byte into a
// shift window of QUERY_MAX bytes and checks it against the aligned query with
// up to 16 parallel byte compares. The output register lets a new request in
// while a verdict waits. Configuration writes are always ready and must be
// issued only while no record is in flight.
module record_filter_substring_match_top
  import rfsm_pkg::*;
#(
  parameter int unsigned QUERY_MAX = QueryMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteW-1:0]     text_byte_i,
  input  logic                 byte_present_i,
  input  logic                 record_end_i,
  input  logic [CategoryW-1:0] category_i,
  input  logic [DateW-1:0]     record_date_i,
  input  logic [TagW-1:0]      record_tags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 accepted_o,
  output logic                 text_found_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CmpN  = (QUERY_MAX < QueryChars) ? QUERY_MAX : QueryChars;
  localparam int unsigned SeenW = $clog2(QUERY_MAX + 1);
  localparam int unsigned CmpW  = (SeenW > QueryLenW) ? SeenW : QueryLenW;
  localparam int unsigned QIdxW = $clog2(QueryChars);

  // configuration registers
  logic [QueryChars-1:0][ByteW-1:0] query_q;
  logic [QueryLenW-1:0]             query_len_q;
  logic [CategoryN-1:0]             category_mask_q;
  logic [DateW-1:0]                 range_start_q;
  logic [DateW-1:0]                 range_end_q;
  logic [TagW-1:0]                  tag_mask_q;
  logic [EnableW-1:0]               enables_q;

  // input register
  logic                 s1_valid_q;
  logic [ByteW-1:0]     s1_byte_q;
  logic                 s1_present_q;
  logic                 s1_end_q;
  logic [CategoryW-1:0] s1_category_q;
  logic [DateW-1:0]     s1_date_q;
  logic [TagW-1:0]      s1_tags_q;

  // record state
  logic [ByteW-1:0] win_q [QUERY_MAX];
  logic [ByteW-1:0] win_d [QUERY_MAX];
  logic [SeenW-1:0] seen_q, seen_d;
  logic             found_q;

  // result register
  logic out_valid_q;
  logic accepted_q;
  logic text_found_q;

  logic                 out_free;
  logic                 advance;
  logic [QueryLenW-1:0] used_len;
  logic [ByteW-1:0]     pat [CmpN];
  logic                 hit;
  logic                 found_new;
  logic                 text_ok;
  logic                 cat_ok;
  logic                 date_ok;
  logic                 tag_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q         <= '0;
      query_len_q     <= '0;
      category_mask_q <= '0;
      range_start_q   <= '0;
      range_end_q     <= '1;
      tag_mask_q      <= '0;
      enables_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgQueryFirst:   query_q[QueryChars/2-1:0] <= cfg_data_i;
        CfgQueryLast:    query_q[QueryChars-1:QueryChars/2] <= cfg_data_i;
        CfgQueryLength:  query_len_q <= cfg_data_i[QueryLenW-1:0];
        CfgCategoryMask: category_mask_q <= cfg_data_i[CategoryN-1:0];
        CfgRangeStart:   range_start_q <= cfg_data_i[DateW-1:0];
        CfgRangeEnd:     range_end_q <= cfg_data_i[DateW-1:0];
        CfgTagMask:      tag_mask_q <= cfg_data_i[TagW-1:0];
        CfgTestEnables:  enables_q <= cfg_data_i[EnableW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!s1_end_q || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q     <= text_byte_i;
      s1_present_q  <= byte_present_i;
      s1_end_q      <= record_end_i;
      s1_category_q <= category_i;
      s1_date_q     <= record_date_i;
      s1_tags_q     <= record_tags_i;
    end
  end

  assign used_len = (query_len_q > QueryLenW'(CmpN)) ? QueryLenW'(CmpN) : query_len_q;

  // window slot j must hold query char (used_len-1-j); slot 0 is the newest byte
  always_comb begin
    for (int j = 0; j < CmpN; j++) begin
      pat[j] = fold_char(query_q[QIdxW'(used_len - QueryLenW'(j) - QueryLenW'(1))]);
    end
  end

  always_comb begin
    win_d[0] = fold_char(s1_byte_q);
    for (int k = 1; k < QUERY_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
    seen_d = (seen_q == SeenW'(QUERY_MAX)) ? seen_q : seen_q + SeenW'(1);
  end

  always_comb begin
    hit = s1_present_q && (used_len != '0) && (CmpW'(seen_d) >= CmpW'(used_len));
    for (int j = 0; j < CmpN; j++) begin
      if ((QueryLenW'(j) < used_len) && (win_d[j] != pat[j])) hit = 1'b0;
    end
  end

  assign found_new = found_q || hit;
  assign text_ok   = (used_len == '0) || found_new;
  assign cat_ok    = !enables_q[EnCategory] || category_mask_q[s1_category_q];
  assign date_ok   = !enables_q[EnDate] ||
                     ((s1_date_q >= range_start_q) && (s1_date_q <= range_end_q));
  assign tag_ok    = !enables_q[EnTag] || ((s1_tags_q & tag_mask_q) != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QUERY_MAX; k++) win_q[k] <= '0;
      seen_q  <= '0;
      found_q <= 1'b0;
    end else if (advance) begin
      if (s1_end_q) begin
        for (int k = 0; k < QUERY_MAX; k++) win_q[k] <= '0;
        seen_q  <= '0;
        found_q <= 1'b0;
      end else if (s1_present_q) begin
        win_q   <= win_d;
        seen_q  <= seen_d;
        found_q <= found_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_end_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_end_q) begin
      accepted_q   <= text_ok && cat_ok && date_ok && tag_ok;
      text_found_q <= text_ok;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign text_found_o = text_found_q;

endmodule

// ===== rtl/rfsm_checker.sv =====
// Port-level checks for the record filter, bound to its top level.
`include "record_filter_substring_match_top_macros.svh"

module rfsm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic record_end_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic accepted_o,
  input logic text_found_o
);

  `RFSM_ASSERT_NEXT(a_out_valid_hold, out_valid_o && !out_ready_i, out_valid_o,
                    "verdict dropped while stalled")

  `RFSM_ASSERT_NEXT(a_out_data_hold, out_valid_o && !out_ready_i,
                    $stable(accepted_o) && $stable(text_found_o),
                    "verdict changed while stalled")

  // a fresh verdict comes from a record end taken at the input
  `RFSM_ASSERT_IMPL(a_verdict_source, $rose(out_valid_o),
                    $past(in_valid_i && in_ready_o && record_end_i, 2),
                    "verdict without record end")

  `RFSM_ASSERT_IMPL(a_accept_needs_text, out_valid_o && accepted_o, text_found_o,
                    "accepted without text match")

endmodule

bind record_filter_substring_match_top rfsm_checker u_rfsm_checker (.*);
